// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define EMFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("emfd: assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define EMFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("emfd: implication failed");

`endif

// ===== rtl/core/emfd_pkg.sv =====
// Shared constants, types and state encoding of the MAV fibrillation detector.
`default_nettype none

package emfd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_RATE    = 1024;
  localparam int MIN_RATE    = 32;
  localparam int RATE_W      = 11;
  localparam int CNT_W       = 10;
  localparam int SEC_W       = 3;
  localparam int ABS_W       = SAMPLE_BITS;
  localparam int SUM_W       = 26;
  localparam int WSUM_W      = SUM_W + 1;
  localparam int ACC_W       = 19;
  localparam int AVG_W       = 17;
  localparam int THR_W       = 16;
  localparam int FRAC_BITS   = 16;
  localparam int DEN_W       = 27;
  localparam int QUO_W       = 22;
  localparam int PRESHIFT    = QUO_W - FRAC_BITS;
  localparam int DIV_STEPS   = QUO_W;
  localparam int DIV_CNT_W   = 5;
  localparam int MUL_STEPS   = RATE_W;
  localparam int MUL_CNT_W   = 4;
  localparam int WINDOWS     = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [SEC_W-1:0]  LAST_CHUNK = SEC_W'(7);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(250);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(17695);
  localparam logic [RATE_W-1:0] RATE_LOW   = RATE_W'(MIN_RATE);
  localparam logic [RATE_W-1:0] RATE_HIGH  = RATE_W'(MAX_RATE);
  localparam logic [QUO_W-1:0]  Q16_ONE    = QUO_W'(1 << FRAC_BITS);
  localparam logic [ACC_W-1:0]  ACC_MAX    = ACC_W'(WINDOWS << FRAC_BITS);
  localparam logic [DEN_W-1:0]  WIN_COUNT  = DEN_W'(WINDOWS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE      = 2'd0,
    CFG_THRESHOLD = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MAV_START,
    ST_MAV_WAIT,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DEN_W-1:0] rem0;
    logic [QUO_W-1:0] bits;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/ecg_mav_fibrillation_detector_unit.sv =====
// Top level of the MAV ventricular-fibrillation detector.
`default_nettype none

`include "assert_macros.svh"

// Accepts one filtered ECG word per handshake and cuts the stream into
// 8-second sections of eight chunks of fs samples (fs from register 0, held
// within 32..1024). Each chunk keeps its absolute sum and absolute maximum;
// each pair of adjacent chunks forms a window whose MAV, sum / (max * 2 * fs)
// in Q1.16 and capped at 1.0, is added to an accumulator. At every section
// end one result word is emitted: the average of the seven window values,
// the flag (average above register 1), the flat-window mark and the sticky
// fatal bit of the record. A window with zero maximum marks the section flat:
// flag and average then read zero. Raising new_record with a sample clears
// all counters, sums and the fatal bit before that sample counts; a partial
// section at the end of a record yields nothing. A sample that does not close
// a chunk leaves the input ready. A sample that closes a chunk stalls the
// input while the 11-step shift-add multiplier forms max * 2 * fs and the
// 22-step restoring divider forms the window MAV (both are skipped when the
// window is flat or the chunk opens a section). The sample that closes a
// section also has the same divider divide the accumulator by seven, and it
// waits there if the previous result word is still stalled. The
// configuration port is always ready; write it only while the block is
// idle.
module ecg_mav_fibrillation_detector_unit (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  // sample channel
  input  wire                                        in_valid_i,
  output logic                                       in_stall_o,
  input  wire signed [emfd_pkg::SAMPLE_BITS-1:0]     sample_i,
  input  wire                                        new_record_i,
  // result channel
  output logic                                       out_valid_o,
  input  wire                                        out_stall_i,
  output logic                                       section_flag_o,
  output logic [emfd_pkg::AVG_W-1:0]                 average_mav_o,
  output logic                                       flat_window_o,
  output logic                                       fatal_o,
  // configuration write channel
  input  wire                                        cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire [emfd_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  wire [emfd_pkg::CFG_DATA_W-1:0]             cfg_data_i
);

  // configuration
  logic [emfd_pkg::RATE_W-1:0] rate_q;
  logic [emfd_pkg::THR_W-1:0]  thr_q;
  logic [emfd_pkg::RATE_W-1:0] fs;

  // record state
  logic [emfd_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [emfd_pkg::SEC_W-1:0]  sec_q, sec_d;
  logic [emfd_pkg::SUM_W-1:0]  prev_sum_q, prev_sum_d;
  logic [emfd_pkg::ABS_W-1:0]  prev_max_q, prev_max_d;
  logic [emfd_pkg::SUM_W-1:0]  cur_sum_q, cur_sum_d;
  logic [emfd_pkg::ABS_W-1:0]  cur_max_q, cur_max_d;
  logic [emfd_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic                        flat_q, flat_d;
  logic                        fatal_q, fatal_d;

  // window work registers
  logic [emfd_pkg::WSUM_W-1:0]    win_sum_q, win_sum_d;
  logic                           sec_end_q, sec_end_d;
  logic [emfd_pkg::DEN_W-1:0]     den_q, den_d;
  logic [emfd_pkg::DEN_W-1:0]     mcand_q, mcand_d;
  logic [emfd_pkg::RATE_W-1:0]    mplier_q, mplier_d;
  logic [emfd_pkg::MUL_CNT_W-1:0] mul_cnt_q, mul_cnt_d;
  logic [emfd_pkg::AVG_W-1:0]     avg_q, avg_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic                        flag_q, flag_d;
  logic [emfd_pkg::AVG_W-1:0]  avg_out_q, avg_out_d;
  logic                        flat_out_q, flat_out_d;
  logic                        fatal_out_q, fatal_out_d;

  emfd_pkg::state_e   state_q, state_d;
  emfd_pkg::div_req_t div_req;
  emfd_pkg::div_rsp_t div_rsp;

  // per-sample datapath
  logic                           in_acc, out_acc;
  logic [emfd_pkg::ABS_W-1:0]     abs_val;
  logic [emfd_pkg::CNT_W-1:0]     cnt_base;
  logic [emfd_pkg::SEC_W-1:0]     sec_base;
  logic [emfd_pkg::SUM_W-1:0]     prev_sum_base, cur_sum_base, cur_sum_new;
  logic [emfd_pkg::ABS_W-1:0]     prev_max_base, cur_max_base, cur_max_new;
  logic [emfd_pkg::ABS_W-1:0]     win_max;
  logic [emfd_pkg::WSUM_W-1:0]    win_sum;
  logic                           chunk_end, has_window, sec_last, win_flat;
  logic [emfd_pkg::QUO_W-1:0]     mav_clamped;
  logic [emfd_pkg::AVG_W-1:0]     avg_final;
  logic                           flag_final;
  logic                           mul_last;
  logic                           out_free;

  assign cfg_ready_o = 1'b1;

  // clamp the sample rate into its supported range
  always_comb begin
    if (rate_q < emfd_pkg::RATE_LOW) begin
      fs = emfd_pkg::RATE_LOW;
    end else if (rate_q > emfd_pkg::RATE_HIGH) begin
      fs = emfd_pkg::RATE_HIGH;
    end else begin
      fs = rate_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= emfd_pkg::RATE_RESET;
      thr_q  <= emfd_pkg::THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (emfd_pkg::cfg_reg_e'(cfg_index_i))
        emfd_pkg::CFG_RATE:      rate_q <= cfg_data_i[emfd_pkg::RATE_W-1:0];
        emfd_pkg::CFG_THRESHOLD: thr_q  <= cfg_data_i[emfd_pkg::THR_W-1:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign mul_last = mul_cnt_q == emfd_pkg::MUL_CNT_W'(emfd_pkg::MUL_STEPS - 1);

  // Sample path: apply a record clear first, then fold in |sample|. The most
  // negative sample folds to 2^(SAMPLE_BITS-1), which two's negation gives.
  always_comb begin
    abs_val       = sample_i[emfd_pkg::SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;
    cnt_base      = new_record_i ? '0 : cnt_q;
    sec_base      = new_record_i ? '0 : sec_q;
    prev_sum_base = new_record_i ? '0 : prev_sum_q;
    prev_max_base = new_record_i ? '0 : prev_max_q;
    cur_sum_base  = new_record_i ? '0 : cur_sum_q;
    cur_max_base  = new_record_i ? '0 : cur_max_q;
    cur_sum_new   = cur_sum_base + emfd_pkg::SUM_W'(abs_val);
    cur_max_new   = (abs_val > cur_max_base) ? abs_val : cur_max_base;
    // a lowered rate ends an overlong chunk on its next sample
    chunk_end     = ({1'b0, cnt_base} + 1'b1) >= fs;
    has_window    = sec_base != '0;
    sec_last      = sec_base == emfd_pkg::LAST_CHUNK;
    win_sum       = {1'b0, prev_sum_base} + {1'b0, cur_sum_new};
    win_max       = (prev_max_base > cur_max_new) ? prev_max_base : cur_max_new;
    win_flat      = win_max == '0;
  end

  // cap the window MAV at 1.0 in Q1.16
  assign mav_clamped = (div_rsp.quotient > emfd_pkg::Q16_ONE) ?
                       emfd_pkg::Q16_ONE : div_rsp.quotient;

  // section decision from the held average and flat mark
  assign avg_final  = flat_q ? '0 : avg_q;
  assign flag_final = !flat_q && (avg_final > {1'b0, thr_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      emfd_pkg::ST_IDLE: begin
        if (in_acc && chunk_end) begin
          if (has_window && !win_flat) begin
            state_d = emfd_pkg::ST_MUL;
          end else if (sec_last) begin
            state_d = emfd_pkg::ST_AVG_START;
          end
        end
      end
      emfd_pkg::ST_MUL: begin
        if (mul_last) begin
          state_d = emfd_pkg::ST_MAV_START;
        end
      end
      emfd_pkg::ST_MAV_START: state_d = emfd_pkg::ST_MAV_WAIT;
      emfd_pkg::ST_MAV_WAIT: begin
        if (div_rsp.done) begin
          state_d = sec_end_q ? emfd_pkg::ST_AVG_START : emfd_pkg::ST_IDLE;
        end
      end
      emfd_pkg::ST_AVG_START: state_d = emfd_pkg::ST_AVG_WAIT;
      emfd_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_d = emfd_pkg::ST_DONE;
        end
      end
      emfd_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = emfd_pkg::ST_IDLE;
        end
      end
      default: state_d = emfd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: stall and divider requests
  always_comb begin
    in_stall_o          = 1'b1;
    div_req.start       = 1'b0;
    div_req.rem0        = '0;
    div_req.bits        = '0;
    div_req.divisor     = emfd_pkg::WIN_COUNT;
    case (state_q)
      emfd_pkg::ST_IDLE: in_stall_o = 1'b0;
      emfd_pkg::ST_MAV_START: begin
        // numerator is win_sum << 16; its top bits start the remainder
        div_req.start   = 1'b1;
        div_req.rem0    = emfd_pkg::DEN_W'(win_sum_q >> emfd_pkg::PRESHIFT);
        div_req.bits    = {win_sum_q[emfd_pkg::PRESHIFT-1:0],
                           emfd_pkg::FRAC_BITS'(0)};
        div_req.divisor = den_q;
      end
      emfd_pkg::ST_AVG_START: begin
        div_req.start   = 1'b1;
        div_req.bits    = emfd_pkg::QUO_W'(acc_q);
      end
      default: begin
        // hold stall, no request
      end
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // register next values
  always_comb begin
    cnt_d       = cnt_q;
    sec_d       = sec_q;
    prev_sum_d  = prev_sum_q;
    prev_max_d  = prev_max_q;
    cur_sum_d   = cur_sum_q;
    cur_max_d   = cur_max_q;
    acc_d       = acc_q;
    flat_d      = flat_q;
    fatal_d     = fatal_q;
    win_sum_d   = win_sum_q;
    sec_end_d   = sec_end_q;
    den_d       = den_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    mul_cnt_d   = mul_cnt_q;
    avg_d       = avg_q;
    out_valid_d = out_acc ? 1'b0 : out_valid_q;
    flag_d      = flag_q;
    avg_out_d   = avg_out_q;
    flat_out_d  = flat_out_q;
    fatal_out_d = fatal_out_q;

    if (in_acc) begin
      acc_d   = new_record_i ? '0 : acc_q;
      flat_d  = new_record_i ? 1'b0 : flat_q;
      fatal_d = new_record_i ? 1'b0 : fatal_q;
      if (!chunk_end) begin
        cnt_d      = cnt_base + 1'b1;
        sec_d      = sec_base;
        prev_sum_d = prev_sum_base;
        prev_max_d = prev_max_base;
        cur_sum_d  = cur_sum_new;
        cur_max_d  = cur_max_new;
      end else begin
        cnt_d     = '0;
        win_sum_d = win_sum;
        sec_end_d = sec_last;
        if (has_window && win_flat) begin
          flat_d = 1'b1;
        end
        // load the shift-add multiplier with max * 2 and fs
        den_d     = '0;
        mcand_d   = {emfd_pkg::DEN_W'(win_max)} << 1;
        mplier_d  = fs;
        mul_cnt_d = '0;
        if (sec_last) begin
          sec_d      = '0;
          prev_sum_d = '0;
          prev_max_d = '0;
        end else begin
          sec_d      = sec_base + 1'b1;
          prev_sum_d = cur_sum_new;
          prev_max_d = cur_max_new;
        end
        cur_sum_d = '0;
        cur_max_d = '0;
      end
    end

    case (state_q)
      emfd_pkg::ST_MUL: begin
        if (mplier_q[0]) begin
          den_d = den_q + mcand_q;
        end
        mcand_d   = mcand_q << 1;
        mplier_d  = mplier_q >> 1;
        mul_cnt_d = mul_cnt_q + 1'b1;
      end
      emfd_pkg::ST_MAV_WAIT: begin
        if (div_rsp.done) begin
          acc_d = acc_q + emfd_pkg::ACC_W'(mav_clamped);
        end
      end
      emfd_pkg::ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          avg_d = div_rsp.quotient[emfd_pkg::AVG_W-1:0];
        end
      end
      emfd_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          flag_d      = flag_final;
          avg_out_d   = avg_final;
          flat_out_d  = flat_q;
          fatal_out_d = fatal_q | flag_final;
          fatal_d     = fatal_q | flag_final;
          acc_d       = '0;
          flat_d      = 1'b0;
        end
      end
      default: begin
        // hold
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= emfd_pkg::ST_IDLE;
      cnt_q       <= '0;
      sec_q       <= '0;
      prev_sum_q  <= '0;
      prev_max_q  <= '0;
      cur_sum_q   <= '0;
      cur_max_q   <= '0;
      acc_q       <= '0;
      flat_q      <= 1'b0;
      fatal_q     <= 1'b0;
      sec_end_q   <= 1'b0;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sec_q       <= sec_d;
      prev_sum_q  <= prev_sum_d;
      prev_max_q  <= prev_max_d;
      cur_sum_q   <= cur_sum_d;
      cur_max_q   <= cur_max_d;
      acc_q       <= acc_d;
      flat_q      <= flat_d;
      fatal_q     <= fatal_d;
      sec_end_q   <= sec_end_d;
      mul_cnt_q   <= mul_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_sum_q   <= win_sum_d;
    den_q       <= den_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    avg_q       <= avg_d;
    flag_q      <= flag_d;
    avg_out_q   <= avg_out_d;
    flat_out_q  <= flat_out_d;
    fatal_out_q <= fatal_out_d;
  end

  emfd_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o    = out_valid_q;
  assign section_flag_o = flag_q;
  assign average_mav_o  = avg_out_q;
  assign flat_window_o  = flat_out_q;
  assign fatal_o        = fatal_out_q;

  `EMFD_ASSERT(a_acc_range, clk_i, rst_ni, acc_q <= emfd_pkg::ACC_MAX)
  `EMFD_ASSERT_IMPL(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q),
                    $past(state_q == emfd_pkg::ST_DONE))
  `EMFD_ASSERT_IMPL(a_wait_has_divider, clk_i, rst_ni,
                    state_q == emfd_pkg::ST_MAV_WAIT || state_q == emfd_pkg::ST_AVG_WAIT,
                    div_rsp.busy || div_rsp.done)

endmodule

`default_nettype wire

// ===== rtl/core/emfd_serial_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

`include "assert_macros.svh"

module emfd_serial_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  emfd_pkg::div_req_t  req_i,
  output emfd_pkg::div_rsp_t  rsp_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [emfd_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [emfd_pkg::DEN_W-1:0]         rem_q, rem_d;
  logic [emfd_pkg::DEN_W-1:0]         div_q, div_d;
  logic [emfd_pkg::QUO_W-1:0]         bits_q, bits_d;
  logic [emfd_pkg::QUO_W-1:0]         quo_q, quo_d;

  logic [emfd_pkg::DEN_W:0] trial;
  logic [emfd_pkg::DEN_W:0] diff;
  logic                     fits;

  always_comb begin
    trial = {rem_q, bits_q[emfd_pkg::QUO_W-1]};
    diff  = trial - {1'b0, div_q};
    fits  = trial >= {1'b0, div_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    bits_d = bits_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.rem0;
      div_d  = req_i.divisor;
      bits_d = req_i.bits;
      quo_d  = '0;
    end else if (busy_q) begin
      // shift in one numerator bit, subtract when the divisor fits
      rem_d  = fits ? diff[emfd_pkg::DEN_W-1:0] : trial[emfd_pkg::DEN_W-1:0];
      quo_d  = {quo_q[emfd_pkg::QUO_W-2:0], fits};
      bits_d = {bits_q[emfd_pkg::QUO_W-2:0], 1'b0};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == emfd_pkg::DIV_CNT_W'(emfd_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    bits_q <= bits_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `EMFD_ASSERT_IMPL(a_rem_below_div, clk_i, rst_ni, busy_q, rem_q < div_q)
  `EMFD_ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_q, $past(busy_q))
  `EMFD_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, busy_q,
                    cnt_q < emfd_pkg::DIV_CNT_W'(emfd_pkg::DIV_STEPS))

endmodule

`default_nettype wire
